// File: rtl/pcgbr_pkg.sv
package pcgbr_pkg;

   localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;

   localparam logic [1:0] OP_SEED   = 2'd0;
   localparam logic [1:0] OP_DRAW32 = 2'd1;
   localparam logic [1:0] OP_DRAW64 = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic CSR_SEED_STATE    = 1'b0;
   localparam logic CSR_SEED_SEQUENCE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WORD,
      ST_MUL_ISSUE,
      ST_MUL_ACC,
      ST_ADV_END,
      ST_CHECK,
      ST_DIV_WAIT,
      ST_OUT
   } fsm_type;

   typedef struct packed {
      logic        done;
      logic [63:0] remainder;
   } div_result_type;

   // XSH-RR output function of the pre-advance state
   function automatic logic [31:0] xsh_rr(input logic [63:0] old);
      logic [31:0] mixed;
      logic [4:0]  rot;
      logic [63:0] dbl;
      logic [63:0] shifted;
      mixed   = 32'(((old >> 18) ^ old) >> 27);
      rot     = old[63:59];
      dbl     = {mixed, mixed};
      shifted = dbl >> rot;
      return shifted[31:0];
   endfunction

endpackage

// File: rtl/pcgbr_mod.sv
// Restoring remainder unit, one quotient bit per cycle.
module pcgbr_mod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [63:0]                    dividend,
   input  logic [63:0]                    divisor,
   output pcgbr_pkg::div_result_type      result
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [63:0] dvs_ff, dvs_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dvd_ff[63]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = diff[64] ? trial[63:0] : diff[63:0];
         dvd_in = {dvd_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign result.done      = done_ff;
   assign result.remainder = rem_ff;

endmodule

// File: rtl/pcg32_bounded_random.sv
// PCG32 generator with bounded draws.
// req channel: req_operation (seed, 32-bit draw, 64-bit draw) and req_range,
// taken when req_valid is high and req_stall low. req_stall is high while a
// transaction is in progress; one transaction is handled at a time.
// rsp channel: rsp_value with rsp_valid; it holds until rsp_stall is low.
// Seed gives no response; unused operation code is dropped.
// All 64-bit products go through one shared 32x32 multiplier, one partial
// product at a time (ST_MUL_ISSUE, then ST_MUL_ACC). An LCG advance ends in
// ST_ADV_END, which adds the increment; a draw forms its word in ST_WORD first.
// The first rejection check that finds lo below n runs a serial remainder for
// the threshold; each retry repeats word generation and the product.
// Maximal range returns the raw word, no product.
// csr_ writes load seed_state / seed_sequence; write only when idle.
// Synchronous reset: state 0, increment 1, seed registers 0, idle.
module pcg32_bounded_random (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [63:0] req_range,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   pcgbr_pkg::fsm_type fsm_ff, fsm_in;
   logic [63:0]  state_ff, state_in;
   logic [63:0]  inc_ff, inc_in;
   logic [63:0]  seed_state_ff, seed_state_in;
   logic [63:0]  seed_seq_ff, seed_seq_in;
   logic [1:0]   op_ff, op_in;
   logic [63:0]  n_ff, n_in;
   logic         max_ff, max_in;
   logic [63:0]  x_ff, x_in;
   logic         half_ff, half_in;
   logic         lcg_ff, lcg_in;
   logic [1:0]   k_ff, k_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  p_ff;
   logic [63:0]  lim_ff, lim_in;
   logic         lim_vld_ff, lim_vld_in;
   logic [63:0]  value_ff, value_in;

   logic [63:0]  src_a, src_b;
   logic [31:0]  mul_a, mul_b;
   logic [127:0] part;
   logic [1:0]   k_last;
   logic         op64;
   logic [31:0]  word;
   logic [63:0]  lo, hi;
   logic         dv_start;
   logic [63:0]  dv_dividend;
   pcgbr_pkg::div_result_type dv_res;

   pcgbr_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_dividend),
      .divisor  (n_ff),
      .result   (dv_res)
   );

   assign op64  = (op_ff == pcgbr_pkg::OP_DRAW64);
   assign word  = pcgbr_pkg::xsh_rr(state_ff);
   assign src_a = lcg_ff ? state_ff : x_ff;
   assign src_b = lcg_ff ? pcgbr_pkg::LCG_MULT : n_ff;
   assign mul_a = k_ff[0] ? src_a[63:32] : src_a[31:0];
   assign mul_b = k_ff[1] ? src_b[63:32] : src_b[31:0];
   assign lo    = op64 ? acc_ff[63:0] : {32'd0, acc_ff[31:0]};
   assign hi    = op64 ? acc_ff[127:64] : {32'd0, acc_ff[63:32]};
   assign dv_dividend = op64 ? (64'd0 - n_ff) : {32'd0, 32'd0 - n_ff[31:0]};

   always_comb begin
      case ({1'b0, k_ff[0]} + {1'b0, k_ff[1]})
         2'd0:    part = {64'd0, p_ff};
         2'd1:    part = {32'd0, p_ff, 32'd0};
         default: part = {p_ff, 64'd0};
      endcase
      if (lcg_ff) k_last = 2'd2;
      else if (op64) k_last = 2'd3;
      else k_last = 2'd0;
   end

   always_comb begin
      fsm_in        = fsm_ff;
      state_in      = state_ff;
      inc_in        = inc_ff;
      seed_state_in = seed_state_ff;
      seed_seq_in   = seed_seq_ff;
      op_in         = op_ff;
      n_in          = n_ff;
      max_in        = max_ff;
      x_in          = x_ff;
      half_in       = half_ff;
      lcg_in        = lcg_ff;
      k_in          = k_ff;
      acc_in        = acc_ff;
      lim_in        = lim_ff;
      lim_vld_in    = lim_vld_ff;
      value_in      = value_ff;
      dv_start      = 1'b0;

      if (csr_write_enable) begin
         case (csr_index)
            pcgbr_pkg::CSR_SEED_STATE:    seed_state_in = csr_data;
            pcgbr_pkg::CSR_SEED_SEQUENCE: seed_seq_in   = csr_data;
            default: ;
         endcase
      end

      case (fsm_ff)
         pcgbr_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_operation;
               half_in    = 1'b0;
               lim_vld_in = 1'b0;
               case (req_operation)
                  pcgbr_pkg::OP_SEED: begin
                     // first step from zero state yields the increment
                     inc_in   = {seed_seq_ff[62:0], 1'b1};
                     state_in = {seed_seq_ff[62:0], 1'b1} + seed_state_ff;
                     lcg_in   = 1'b1;
                     k_in     = '0;
                     acc_in   = '0;
                     fsm_in   = pcgbr_pkg::ST_MUL_ISSUE;
                  end
                  pcgbr_pkg::OP_DRAW32: begin
                     n_in   = {32'd0, req_range[31:0] + 32'd1};
                     max_in = (req_range[31:0] == 32'hFFFF_FFFF);
                     fsm_in = pcgbr_pkg::ST_WORD;
                  end
                  pcgbr_pkg::OP_DRAW64: begin
                     n_in   = req_range + 64'd1;
                     max_in = (req_range == 64'hFFFF_FFFF_FFFF_FFFF);
                     fsm_in = pcgbr_pkg::ST_WORD;
                  end
                  default: ;
               endcase
            end
         end
         pcgbr_pkg::ST_WORD: begin
            x_in    = op64 ? {x_ff[31:0], word} : {32'd0, word};
            half_in = ~half_ff;
            lcg_in  = 1'b1;
            k_in    = '0;
            acc_in  = '0;
            fsm_in  = pcgbr_pkg::ST_MUL_ISSUE;
         end
         pcgbr_pkg::ST_MUL_ISSUE: begin
            fsm_in = pcgbr_pkg::ST_MUL_ACC;
         end
         pcgbr_pkg::ST_MUL_ACC: begin
            acc_in = acc_ff + part;
            if (k_ff == k_last) begin
               fsm_in = lcg_ff ? pcgbr_pkg::ST_ADV_END : pcgbr_pkg::ST_CHECK;
            end else begin
               k_in   = k_ff + 2'd1;
               fsm_in = pcgbr_pkg::ST_MUL_ISSUE;
            end
         end
         pcgbr_pkg::ST_ADV_END: begin
            state_in = acc_ff[63:0] + inc_ff;
            if (op_ff == pcgbr_pkg::OP_SEED) begin
               fsm_in = pcgbr_pkg::ST_IDLE;
            end else if (op64 && half_ff) begin
               fsm_in = pcgbr_pkg::ST_WORD;
            end else if (max_ff) begin
               value_in = x_ff;
               fsm_in   = pcgbr_pkg::ST_OUT;
            end else begin
               lcg_in = 1'b0;
               k_in   = '0;
               acc_in = '0;
               fsm_in = pcgbr_pkg::ST_MUL_ISSUE;
            end
         end
         pcgbr_pkg::ST_CHECK: begin
            if (lo < n_ff && !lim_vld_ff) begin
               dv_start = 1'b1;
               fsm_in   = pcgbr_pkg::ST_DIV_WAIT;
            end else if (lo < n_ff && lo < lim_ff) begin
               fsm_in = pcgbr_pkg::ST_WORD;
            end else begin
               value_in = hi;
               fsm_in   = pcgbr_pkg::ST_OUT;
            end
         end
         pcgbr_pkg::ST_DIV_WAIT: begin
            if (dv_res.done) begin
               lim_in     = dv_res.remainder;
               lim_vld_in = 1'b1;
               fsm_in     = pcgbr_pkg::ST_CHECK;
            end
         end
         pcgbr_pkg::ST_OUT: begin
            if (!rsp_stall) fsm_in = pcgbr_pkg::ST_IDLE;
         end
         default: fsm_in = pcgbr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= pcgbr_pkg::ST_IDLE;
         state_ff      <= '0;
         inc_ff        <= 64'd1;
         seed_state_ff <= '0;
         seed_seq_ff   <= '0;
         lim_vld_ff    <= 1'b0;
         half_ff       <= 1'b0;
         lcg_ff        <= 1'b0;
         k_ff          <= '0;
         op_ff         <= pcgbr_pkg::OP_SEED;
         max_ff        <= 1'b0;
      end else begin
         fsm_ff        <= fsm_in;
         state_ff      <= state_in;
         inc_ff        <= inc_in;
         seed_state_ff <= seed_state_in;
         seed_seq_ff   <= seed_seq_in;
         lim_vld_ff    <= lim_vld_in;
         half_ff       <= half_in;
         lcg_ff        <= lcg_in;
         k_ff          <= k_in;
         op_ff         <= op_in;
         max_ff        <= max_in;
      end
      n_ff     <= n_in;
      x_ff     <= x_in;
      acc_ff   <= acc_in;
      lim_ff   <= lim_in;
      value_ff <= value_in;
      p_ff     <= 64'(mul_a) * 64'(mul_b);
   end

   assign req_stall = (fsm_ff != pcgbr_pkg::ST_IDLE);
   assign rsp_valid = (fsm_ff == pcgbr_pkg::ST_OUT);
   assign rsp_value = value_ff;

endmodule
